FILE: design/utcl_pkg.sv
`default_nettype none

package utcl_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned SCALE_W  = 4;
  localparam int unsigned SW_W     = 13;
  localparam int unsigned STEP_W   = SCALE_W + 5;
  localparam int unsigned CMP_W    = ((COORD_W > SW_W) ? COORD_W : SW_W) + 1;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned COLS_W   = 5;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(1);
  localparam logic [SW_W-1:0]    SW_RST    = SW_W'(1024);

  localparam logic [COLS_W-1:0]  NARROW_COLS = COLS_W'(8);
  localparam logic [COLS_W-1:0]  WIDE_COLS   = COLS_W'(16);
  localparam logic [CODE_W-1:0]  NARROW_LIMIT = CODE_W'(8'h7f);
  localparam logic [7:0]         NEWLINE     = 8'h0a;

  // register index, taken from paddr[2]
  localparam logic REG_SCALE        = 1'b0;
  localparam logic REG_SCREEN_WIDTH = 1'b1;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [SW_W-1:0]    screen_width;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        text_byte;
    logic              first;
    logic [PORT_W-1:0] start_x;
    logic [PORT_W-1:0] start_y;
  } item_t;

  typedef struct packed {
    logic              glyph_valid;
    logic [CODE_W-1:0] code_point;
    logic [PORT_W-1:0] glyph_x;
    logic [PORT_W-1:0] glyph_y;
    logic [COLS_W-1:0] glyph_cols;
    logic [PORT_W-1:0] cursor_x;
    logic [PORT_W-1:0] cursor_y;
  } result_t;

  // 20 * scale, the line pitch
  function automatic logic [STEP_W-1:0] line_step(input logic [SCALE_W-1:0] s);
    return (STEP_W'(s) << 4) + (STEP_W'(s) << 2);
  endfunction

endpackage

`default_nettype wire

FILE: design/utcl_cfg.sv
`default_nettype none

module utcl_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [utcl_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [utcl_pkg::DATA_W-1:0]   pwdata,
  output logic      [utcl_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output utcl_pkg::cfg_t                     cfg_o
);

  utcl_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic           reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale        <= utcl_pkg::SCALE_RST;
      cfg_q.screen_width <= utcl_pkg::SW_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        utcl_pkg::REG_SCALE:        cfg_q.scale        <= pwdata[utcl_pkg::SCALE_W-1:0];
        utcl_pkg::REG_SCREEN_WIDTH: cfg_q.screen_width <= pwdata[utcl_pkg::SW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      utcl_pkg::REG_SCALE:        prdata = utcl_pkg::DATA_W'(cfg_q.scale);
      utcl_pkg::REG_SCREEN_WIDTH: prdata = utcl_pkg::DATA_W'(cfg_q.screen_width);
      default:                    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: design/utcl_step.sv
`default_nettype none

module utcl_step (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire utcl_pkg::item_t item_i,
  input  wire utcl_pkg::cfg_t  cfg_i,
  output utcl_pkg::result_t    res_o
);

  localparam int unsigned CW = utcl_pkg::COORD_W;

  logic [utcl_pkg::CODE_W-1:0] code_q, code_d;
  logic [1:0]                  pend_q, pend_d;
  logic [CW-1:0]               x_q, x_d;
  logic [CW-1:0]               y_q, y_d;
  logic [CW-1:0]               org_q, org_d;

  logic [utcl_pkg::CODE_W-1:0] code0;
  logic [1:0]                  pend0;
  logic [CW-1:0]               x0, y0, x1, y1;
  logic [utcl_pkg::STEP_W-1:0] step;
  logic [utcl_pkg::CMP_W-1:0]  reach;
  logic                        emit, wide;
  logic [utcl_pkg::CODE_W-1:0] glyph_code;
  logic [7:0]                  b;

  assign b    = item_i.text_byte;
  assign step = utcl_pkg::line_step(cfg_i.scale);

  always_comb begin
    // a string start reloads the cursor and drops any partial sequence
    if (item_i.first) begin
      x0    = CW'(item_i.start_x);
      y0    = CW'(item_i.start_y);
      org_d = CW'(item_i.start_x);
      pend0 = '0;
      code0 = '0;
    end else begin
      x0    = x_q;
      y0    = y_q;
      org_d = org_q;
      pend0 = pend_q;
      code0 = code_q;
    end

    reach = utcl_pkg::CMP_W'(x0) + utcl_pkg::CMP_W'(step);
    if (reach >= utcl_pkg::CMP_W'(cfg_i.screen_width)) begin
      x1 = org_d;
      y1 = y0 + CW'(step);
    end else begin
      x1 = x0;
      y1 = y0;
    end

    emit       = 1'b0;
    wide       = 1'b0;
    glyph_code = '0;
    code_d     = code0;
    pend_d     = pend0;
    x_d        = x0;
    y_d        = y0;

    if (b == 8'h00) begin
      code_d = '0;
      pend_d = '0;
    end else if (pend0 != 2'd0) begin
      code_d = {code0[utcl_pkg::CODE_W-7:0], b[5:0]};
      pend_d = pend0 - 2'd1;
      if (pend0 == 2'd1) begin
        emit       = 1'b1;
        wide       = 1'b1;
        glyph_code = {code0[utcl_pkg::CODE_W-7:0], b[5:0]};
      end
    end else begin
      x_d = x1;
      y_d = y1;
      if (!b[7]) begin
        if (b == utcl_pkg::NEWLINE) begin
          x_d = org_d;
          y_d = y1 + CW'(step);
        end else begin
          emit       = 1'b1;
          glyph_code = utcl_pkg::CODE_W'(b);
        end
      end else if (b[7:5] == 3'b110) begin
        code_d = utcl_pkg::CODE_W'(b[4:0]);
        pend_d = 2'd1;
      end else if (b[7:4] == 4'he) begin
        code_d = utcl_pkg::CODE_W'(b[3:0]);
        pend_d = 2'd2;
      end
      // other leads: drop after the wrap check
    end

    res_o = '0;
    if (emit) begin
      res_o.glyph_valid = 1'b1;
      res_o.code_point  = glyph_code;
      res_o.glyph_x     = utcl_pkg::PORT_W'(x_d);
      res_o.glyph_y     = utcl_pkg::PORT_W'(y_d);
      res_o.glyph_cols  = (glyph_code < utcl_pkg::NARROW_LIMIT) ?
                          utcl_pkg::NARROW_COLS : utcl_pkg::WIDE_COLS;
      // advance 8 or 16 times scale
      x_d = wide ? x_d + (CW'(cfg_i.scale) << 4) : x_d + (CW'(cfg_i.scale) << 3);
    end
    res_o.cursor_x = utcl_pkg::PORT_W'(x_d);
    res_o.cursor_y = utcl_pkg::PORT_W'(y_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
      pend_q <= '0;
      x_q    <= '0;
      y_q    <= '0;
      org_q  <= '0;
    end else if (en_i) begin
      code_q <= code_d;
      pend_q <= pend_d;
      x_q    <= x_d;
      y_q    <= y_d;
      org_q  <= org_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/utf8_text_cursor_layout.sv
`default_nettype none

// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   text_byte_i, first_i, start_x_i, start_y_i
// out      output     out_valid_o / out_stall_i glyph_valid_o, code_point_o, glyph_x_o,
//                                               glyph_y_o, glyph_cols_o, cursor_x_o, cursor_y_o
// cfg      input      APB write, pready = 1      scale at 0x0, screen_width at 0x4
//
// One byte per cycle sustained while out_stall_i is low; a request passes the input register,
// then the output register. The rate is set by the decode and cursor update loop in utcl_step.
// Reset clears decode state and cursor to zero, scale to 1, screen_width to 1024.
// A stalled result holds in the output register while the input register
// still takes one more request; in_stall_o rises only when both are full.

module utf8_text_cursor_layout (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [utcl_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [utcl_pkg::DATA_W-1:0]   pwdata,
  output logic      [utcl_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    text_byte_i,
  input  wire logic                          first_i,
  input  wire logic [utcl_pkg::PORT_W-1:0]   start_x_i,
  input  wire logic [utcl_pkg::PORT_W-1:0]   start_y_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               glyph_valid_o,
  output logic      [utcl_pkg::CODE_W-1:0]   code_point_o,
  output logic      [utcl_pkg::PORT_W-1:0]   glyph_x_o,
  output logic      [utcl_pkg::PORT_W-1:0]   glyph_y_o,
  output logic      [utcl_pkg::COLS_W-1:0]   glyph_cols_o,
  output logic      [utcl_pkg::PORT_W-1:0]   cursor_x_o,
  output logic      [utcl_pkg::PORT_W-1:0]   cursor_y_o
);

  utcl_pkg::cfg_t    cfg;
  utcl_pkg::item_t   item_q;
  utcl_pkg::result_t res, res_q;
  logic              item_vld_q;
  logic              out_vld_q;
  logic              out_adv;
  logic              step_en;
  logic              in_take;

  utcl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign out_adv    = !out_vld_q || !out_stall_i;
  assign step_en    = item_vld_q && out_adv;
  assign in_stall_o = item_vld_q && !out_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.text_byte <= text_byte_i;
      item_q.first     <= first_i;
      item_q.start_x   <= start_x_i;
      item_q.start_y   <= start_y_i;
    end
  end

  utcl_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step_en),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign glyph_valid_o = res_q.glyph_valid;
  assign code_point_o  = res_q.code_point;
  assign glyph_x_o     = res_q.glyph_x;
  assign glyph_y_o     = res_q.glyph_y;
  assign glyph_cols_o  = res_q.glyph_cols;
  assign cursor_x_o    = res_q.cursor_x;
  assign cursor_y_o    = res_q.cursor_y;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> item_vld_q && out_vld_q)
    else $error("input stalled without a held request");

  a_item_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_q && !out_adv |=> item_vld_q && $stable(item_q))
    else $error("held request lost while output blocked");

  a_result_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en |=> out_vld_q)
    else $error("processed request produced no result");

  a_cols_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.glyph_valid |->
      res_q.glyph_cols == utcl_pkg::NARROW_COLS || res_q.glyph_cols == utcl_pkg::WIDE_COLS)
    else $error("glyph width not 8 or 16");

  a_no_glyph_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_q.glyph_valid |->
      res_q.code_point == '0 && res_q.glyph_cols == '0)
    else $error("glyph fields set without a glyph");

endmodule

`default_nettype wire

FILE: tb/tb_utf8_text_cursor_layout.sv
`timescale 1ns / 100ps

module tb_utf8_text_cursor_layout;

  localparam int unsigned LINE_PITCH  = 20;
  localparam int unsigned NARROW_ADV  = 8;
  localparam int unsigned WIDE_ADV    = 16;
  localparam int unsigned PHASES      = 7;
  localparam int unsigned PHASE_BYTES = 175;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    utcl_pkg::item_t   it;
    bit                known;
    utcl_pkg::result_t want;
  } text_req_t;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            psel        = 1'b0;
  logic                            penable     = 1'b0;
  logic                            pwrite      = 1'b0;
  logic [utcl_pkg::ADDR_W-1:0]     paddr       = '0;
  logic [utcl_pkg::DATA_W-1:0]     pwdata      = '0;
  logic [utcl_pkg::DATA_W-1:0]     prdata;
  logic                            pready;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  logic [7:0]                      text_byte_i = '0;
  logic                            first_i     = 1'b0;
  logic [utcl_pkg::PORT_W-1:0]     start_x_i   = '0;
  logic [utcl_pkg::PORT_W-1:0]     start_y_i   = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic                            glyph_valid_o;
  logic [utcl_pkg::CODE_W-1:0]     code_point_o;
  logic [utcl_pkg::PORT_W-1:0]     glyph_x_o;
  logic [utcl_pkg::PORT_W-1:0]     glyph_y_o;
  logic [utcl_pkg::COLS_W-1:0]     glyph_cols_o;
  logic [utcl_pkg::PORT_W-1:0]     cursor_x_o;
  logic [utcl_pkg::PORT_W-1:0]     cursor_y_o;

  utf8_text_cursor_layout dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_byte_i   (text_byte_i),
    .first_i       (first_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .glyph_valid_o (glyph_valid_o),
    .code_point_o  (code_point_o),
    .glyph_x_o     (glyph_x_o),
    .glyph_y_o     (glyph_y_o),
    .glyph_cols_o  (glyph_cols_o),
    .cursor_x_o    (cursor_x_o),
    .cursor_y_o    (cursor_y_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // layout state mirrored from the block, reset values included
  logic [utcl_pkg::SCALE_W-1:0] cfg_scale  = utcl_pkg::SCALE_RST;
  logic [utcl_pkg::SW_W-1:0]    cfg_width  = utcl_pkg::SW_RST;
  logic [15:0]                  part_code  = '0;
  logic [1:0]                   bytes_left = '0;
  logic [15:0]                  cur_x      = '0;
  logic [15:0]                  cur_y      = '0;
  logic [15:0]                  origin_x   = '0;

  text_req_t         byte_q[$];
  utcl_pkg::result_t glyph_q[$];
  int unsigned       errors     = 0;
  int unsigned       cycles     = 0;
  int unsigned       stall_hold = 0;
  bit                idle_on    = 1'b1;

  logic [utcl_pkg::SCALE_W-1:0] phase_scale[PHASES] =
    '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2, 4'd5};
  logic [utcl_pkg::SW_W-1:0]    phase_width[PHASES] =
    '{13'd4096, 13'd1, 13'd8191, 13'd0, 13'd300, 13'd1024, 13'd700};

  function automatic utcl_pkg::result_t next_glyph(input utcl_pkg::item_t it);
    utcl_pkg::result_t r;
    logic [7:0]        b;
    int unsigned       pitch;
    int unsigned       adv;
    bit                emit;
    r     = '0;
    b     = it.text_byte;
    pitch = LINE_PITCH * cfg_scale;
    adv   = 0;
    emit  = 1'b0;
    if (it.first) begin
      cur_x      = it.start_x;
      origin_x   = it.start_x;
      cur_y      = it.start_y;
      bytes_left = '0;
      part_code  = '0;
    end
    if (b == 8'h00) begin
      bytes_left = '0;
      part_code  = '0;
    end else if (bytes_left != 0) begin
      part_code  = {part_code[9:0], b[5:0]};
      bytes_left = bytes_left - 2'd1;
      if (bytes_left == 0) begin
        emit         = 1'b1;
        r.code_point = part_code;
        adv          = WIDE_ADV;
      end
    end else begin
      // wrap check uses the unwrapped sum
      if (32'(cur_x) + pitch >= 32'(cfg_width)) begin
        cur_x = origin_x;
        cur_y = cur_y + 16'(pitch);
      end
      if (!b[7]) begin
        if (b == utcl_pkg::NEWLINE) begin
          cur_x = origin_x;
          cur_y = cur_y + 16'(pitch);
        end else begin
          emit         = 1'b1;
          r.code_point = 16'(b);
          adv          = NARROW_ADV;
        end
      end else if (b[7:5] == 3'b110) begin
        part_code  = 16'(b[4:0]);
        bytes_left = 2'd1;
      end else if (b[7:4] == 4'he) begin
        part_code  = 16'(b[3:0]);
        bytes_left = 2'd2;
      end
    end
    if (emit) begin
      r.glyph_valid = 1'b1;
      r.glyph_x     = cur_x;
      r.glyph_y     = cur_y;
      r.glyph_cols  = (r.code_point < utcl_pkg::NARROW_LIMIT) ?
                      utcl_pkg::NARROW_COLS : utcl_pkg::WIDE_COLS;
      cur_x         = cur_x + 16'(adv * cfg_scale);
    end
    r.cursor_x = cur_x;
    r.cursor_y = cur_y;
    return r;
  endfunction

  function automatic text_req_t text(input logic [7:0] b, input bit f,
                                     input logic [15:0] sx, input logic [15:0] sy);
    text_req_t t;
    t.it    = '{text_byte: b, first: f, start_x: sx, start_y: sy};
    t.known = 1'b0;
    t.want  = '0;
    return t;
  endfunction

  function automatic text_req_t text_known(input logic [7:0] b, input bit f,
                                           input logic [15:0] sx, input logic [15:0] sy,
                                           input utcl_pkg::result_t want);
    text_req_t t;
    t       = text(b, f, sx, sy);
    t.known = 1'b1;
    t.want  = want;
    return t;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (!idle_on || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic reg_write(input logic idx, input logic [utcl_pkg::DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= utcl_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == utcl_pkg::REG_SCALE) cfg_scale = val[utcl_pkg::SCALE_W-1:0];
    else cfg_width = val[utcl_pkg::SW_W-1:0];
  endtask

  task automatic send_text();
    text_req_t   t;
    int unsigned gap;
    while (byte_q.size() != 0) begin
      t   = byte_q.pop_front();
      gap = pick_gap();
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      text_byte_i <= t.it.text_byte;
      first_i     <= t.it.first;
      start_x_i   <= t.it.start_x;
      start_y_i   <= t.it.start_y;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      // request taken at this edge
      if (t.known) begin
        void'(next_glyph(t.it));
        glyph_q.push_back(t.want);
      end else begin
        glyph_q.push_back(next_glyph(t.it));
      end
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic queue_random_text(input int unsigned count);
    logic [7:0]  seq[$];
    logic [15:0] sx;
    int unsigned kind;
    bit          f;
    while (count > 0) begin
      seq  = {};
      kind = $urandom_range(0, 99);
      if (kind < 38) begin
        seq.push_back(8'($urandom_range(1, 127)));
      end else if (kind < 46) begin
        seq.push_back(utcl_pkg::NEWLINE);
      end else if (kind < 62) begin
        seq.push_back(8'hc0 | 8'($urandom_range(0, 31)));
        seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end else if (kind < 78) begin
        seq.push_back(8'he0 | 8'($urandom_range(0, 15)));
        seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
        seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end else if (kind < 86) begin
        // follow a three-byte lead and at most one continuation with any byte
        seq.push_back(8'he0 | 8'($urandom_range(0, 15)));
        if ($urandom_range(0, 1)) seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
        seq.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 91) begin
        seq.push_back(8'h00);
      end else begin
        seq.push_back(8'($urandom_range(0, 255)));
      end
      foreach (seq[i]) begin
        f  = (i == 0) && ($urandom_range(0, 29) == 0);
        sx = $urandom_range(0, 3) != 0 ? 16'($urandom_range(0, cfg_width)) : 16'($urandom);
        byte_q.push_back(text(seq[i], f, f ? sx : 16'($urandom), 16'($urandom)));
        if (count > 0) count--;
      end
    end
  endtask

  task automatic check_glyph(input utcl_pkg::result_t got);
    utcl_pkg::result_t want;
    if (glyph_q.size() == 0) begin
      $error("glyph result with no request pending");
      errors++;
      return;
    end
    want = glyph_q.pop_front();
    if (got.glyph_valid !== want.glyph_valid) begin
      $error("glyph_valid: expected %0h, got %0h", want.glyph_valid, got.glyph_valid);
      errors++;
    end
    if (got.code_point !== want.code_point) begin
      $error("code_point: expected %0h, got %0h", want.code_point, got.code_point);
      errors++;
    end
    if (got.glyph_x !== want.glyph_x) begin
      $error("glyph_x: expected %0h, got %0h", want.glyph_x, got.glyph_x);
      errors++;
    end
    if (got.glyph_y !== want.glyph_y) begin
      $error("glyph_y: expected %0h, got %0h", want.glyph_y, got.glyph_y);
      errors++;
    end
    if (got.glyph_cols !== want.glyph_cols) begin
      $error("glyph_cols: expected %0h, got %0h", want.glyph_cols, got.glyph_cols);
      errors++;
    end
    if (got.cursor_x !== want.cursor_x) begin
      $error("cursor_x: expected %0h, got %0h", want.cursor_x, got.cursor_x);
      errors++;
    end
    if (got.cursor_y !== want.cursor_y) begin
      $error("cursor_y: expected %0h, got %0h", want.cursor_y, got.cursor_y);
      errors++;
    end
  endtask

  // check results and pick the next stall stretch
  always @(posedge clk_i) begin
    int unsigned pick;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_glyph('{glyph_valid_o, code_point_o, glyph_x_o, glyph_y_o, glyph_cols_o,
                    cursor_x_o, cursor_y_o});
    end
    if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      pick = $urandom_range(0, 99);
      if (!idle_on || pick < 55) begin
        out_stall_i <= 1'b0;
        stall_hold  = $urandom_range(0, 6);
      end else if (pick < 92) begin
        out_stall_i <= 1'b1;
        stall_hold  = $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_hold  = $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    byte_q.push_back(text_known(8'h41, 1'b1, 16'd0, 16'd0,
                     '{1'b1, 16'h41, 16'd0, 16'd0, utcl_pkg::NARROW_COLS, 16'd8, 16'd0}));
    // terminator: no glyph, cursor holds
    byte_q.push_back(text_known(8'h00, 1'b0, 16'd0, 16'd0,
                     '{1'b0, 16'h0, 16'd0, 16'd0, 5'd0, 16'd8, 16'd0}));
    byte_q.push_back(text_known(utcl_pkg::NEWLINE, 1'b0, 16'd0, 16'd0,
                     '{1'b0, 16'h0, 16'd0, 16'd0, 5'd0, 16'd0, 16'd20}));
    byte_q.push_back(text(8'hc3, 1'b0, 16'd0, 16'd0));
    byte_q.push_back(text(8'ha9, 1'b0, 16'd0, 16'd0));
    byte_q.push_back(text(8'he2, 1'b0, 16'd0, 16'd0));
    byte_q.push_back(text(8'h82, 1'b0, 16'd0, 16'd0));
    byte_q.push_back(text(8'hac, 1'b0, 16'd0, 16'd0));
    // stray continuation, four-byte lead and all-ones are dropped
    byte_q.push_back(text(8'h80, 1'b0, 16'd0, 16'd0));
    byte_q.push_back(text(8'hf0, 1'b0, 16'd0, 16'd0));
    byte_q.push_back(text(8'hff, 1'b0, 16'd0, 16'd0));
    // overlong forms of 0x7f and of zero
    byte_q.push_back(text(8'hc1, 1'b0, 16'd0, 16'd0));
    byte_q.push_back(text(8'hbf, 1'b0, 16'd0, 16'd0));
    byte_q.push_back(text(8'hc0, 1'b0, 16'd0, 16'd0));
    byte_q.push_back(text(8'h80, 1'b0, 16'd0, 16'd0));
    byte_q.push_back(text(8'h7f, 1'b0, 16'd0, 16'd0));
    // terminator inside a sequence, then a plain byte
    byte_q.push_back(text(8'he2, 1'b0, 16'd0, 16'd0));
    byte_q.push_back(text(8'h00, 1'b0, 16'd0, 16'd0));
    byte_q.push_back(text(8'h01, 1'b0, 16'd0, 16'd0));
    // any nonzero byte continues a sequence
    byte_q.push_back(text(8'hc3, 1'b0, 16'd0, 16'd0));
    byte_q.push_back(text(8'h41, 1'b0, 16'd0, 16'd0));
    // new string drops the partial sequence; start at the coordinate limit
    byte_q.push_back(text(8'hc3, 1'b0, 16'd0, 16'd0));
    byte_q.push_back(text_known(8'h42, 1'b1, 16'hffff, 16'hffff,
                     '{1'b1, 16'h42, 16'hffff, 16'd19, utcl_pkg::NARROW_COLS, 16'd7,
                       16'd19}));
    // newline that also wraps moves down twice
    byte_q.push_back(text_known(utcl_pkg::NEWLINE, 1'b1, 16'd1010, 16'd100,
                     '{1'b0, 16'h0, 16'd0, 16'd0, 5'd0, 16'd1010, 16'd140}));
    send_text();

    phase_scale[PHASES-1] = 4'($urandom_range(1, 8));
    phase_width[PHASES-1] = 13'($urandom_range(1, 4096));
    for (int p = 0; p < PHASES; p++) begin
      // registers change only with the pipeline drained
      while (glyph_q.size() != 0) @(posedge clk_i);
      idle_on <= (p != 2) && ($urandom_range(0, 3) != 0);
      reg_write(utcl_pkg::REG_SCALE,
                ($urandom & ~32'hf) | utcl_pkg::DATA_W'(phase_scale[p]));
      reg_write(utcl_pkg::REG_SCREEN_WIDTH,
                ($urandom & ~32'h1fff) | utcl_pkg::DATA_W'(phase_width[p]));
      byte_q.push_back(text(8'h41, 1'b1, 16'($urandom_range(0, phase_width[p])),
                            16'($urandom)));
      queue_random_text(PHASE_BYTES);
      send_text();
    end

    while (glyph_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
